// ----- sv/div128_pkg.sv -----
// Package: shared types and constants for the 128-by-64 divider pipeline.
package div128_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned NumW = 128;
	// Quotient bits resolved per pipeline stage.
	localparam int unsigned BitsPerStage = 4;
	localparam int unsigned NumStages = NumW / BitsPerStage;

	// Division state that travels down the pipeline.
	typedef struct packed {
		logic [NumW-1:0]  num;
		logic [WordW-1:0] den;
		logic [WordW-1:0] rem;
		logic             neg_q;
		logic             neg_r;
		logic             zero;
		logic [WordW-1:0] low_in;
	} div_state_t;

endpackage

// ----- sv/div128_stage.sv -----
// Module: one divider stage resolving BitsPerStage quotient bits, with its pipeline register.
module div128_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    valid_in,
	input  div128_pkg::div_state_t  state_in,
	output logic                    valid_s1,
	output div128_pkg::div_state_t  state_s1
);

	div128_pkg::div_state_t nxt;
	logic [div128_pkg::WordW-1:0] r;
	logic [div128_pkg::NumW-1:0]  n;
	logic                         top;

	// Run restoring steps, shifting quotient bits into the low end of num.
	always_comb begin
		r = state_in.rem;
		n = state_in.num;
		top = 1'b0;
		for (int i = 0; i < div128_pkg::BitsPerStage; i++) begin
			top = r[div128_pkg::WordW-1];
			r = {r[div128_pkg::WordW-2:0], n[div128_pkg::NumW-1]};
			n = {n[div128_pkg::NumW-2:0], 1'b0};
			if (top || r >= state_in.den) begin
				r = r - state_in.den;
				n[0] = 1'b1;
			end
		end
		nxt = state_in;
		nxt.rem = r;
		nxt.num = n;
	end

	// Hold while stalled, advance otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_s1 <= nxt;
		end
	end

endmodule

// ----- sv/divide_128_by_64_top.sv -----
// Top level: pipelined 128-by-64 signed/unsigned integer divider.
// Usage: present a word on the input channel (valid/ready) with req_type,
// dividend_low, dividend_high and divisor_value; the result word appears on
// the output channel (out_valid/out_ready) with the quotient halves, the
// remainder and zero_divisor.
// Pipeline: an operand sign-handling register, 32 stages of four quotient
// bits each, a result sign-correction register and an output register.
// Throughput: one word per cycle while no result is stalled at the output;
// the stage count is set by the 128 quotient bits at four bits per stage.
// The whole pipeline advances as one: when the receiver holds out_ready low
// while a result waits, every stage holds and in_ready drops for as long as
// that word waits, so nothing is lost or repeated.
// Reset clears every valid bit; the block is ready on the first cycle after.
// A zero divisor gives all-ones quotient, the low dividend half as
// remainder and zero_divisor set.
module divide_128_by_64_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [63:0] dividend_low,
	input  logic [63:0] dividend_high,
	input  logic [63:0] divisor_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] quotient_low,
	output logic [63:0] quotient_high,
	output logic [63:0] remainder_value,
	output logic        zero_divisor
);

	logic                   advance;
	logic                   valid_s0;
	div128_pkg::div_state_t state_s0;
	div128_pkg::div_state_t in_state;
	logic                   stg_valid [div128_pkg::NumStages+1];
	div128_pkg::div_state_t stg_state [div128_pkg::NumStages+1];
	logic                   valid_sf;
	logic [127:0]           quo_sf;
	logic [63:0]            rem_sf;
	logic                   zero_sf;
	logic                   neg_q_sf;
	logic                   neg_r_sf;
	logic [127:0]           quo_fix;
	logic [63:0]            rem_fix;

	// Stall the whole pipe only when a result waits and is not taken.
	assign advance  = !(out_valid && !out_ready);
	assign in_ready = advance;

	// Take magnitudes of the operands in signed mode.
	always_comb begin
		in_state.zero   = (divisor_value == '0);
		in_state.low_in = dividend_low;
		in_state.neg_r  = req_type && dividend_high[63];
		in_state.neg_q  = in_state.neg_r ^ (req_type && divisor_value[63]);
		in_state.num    = in_state.neg_r ? (~{dividend_high, dividend_low} + 128'd1)
			: {dividend_high, dividend_low};
		in_state.den    = (req_type && divisor_value[63]) ? (~divisor_value + 64'd1)
			: divisor_value;
		in_state.rem    = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (advance) begin
			valid_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_s0 <= in_state;
		end
	end

	assign stg_valid[0] = valid_s0;
	assign stg_state[0] = state_s0;

	// Chain the quotient stages.
	for (genvar g = 0; g < div128_pkg::NumStages; g++) begin : g_stage
		div128_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.valid_in (stg_valid[g]),
			.state_in (stg_state[g]),
			.valid_s1 (stg_valid[g+1]),
			.state_s1 (stg_state[g+1])
		);
	end

	// Register results, inverted where negative, and the special-case fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sf <= 1'b0;
		end else if (advance) begin
			valid_sf <= stg_valid[div128_pkg::NumStages];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			zero_sf <= stg_state[div128_pkg::NumStages].zero;
			quo_sf  <= stg_state[div128_pkg::NumStages].zero ? '1
				: (stg_state[div128_pkg::NumStages].neg_q
					? ~stg_state[div128_pkg::NumStages].num
					: stg_state[div128_pkg::NumStages].num);
			rem_sf  <= stg_state[div128_pkg::NumStages].zero
				? stg_state[div128_pkg::NumStages].low_in
				: (stg_state[div128_pkg::NumStages].neg_r
					? ~stg_state[div128_pkg::NumStages].rem
					: stg_state[div128_pkg::NumStages].rem);
		end
	end

	// Finish the negation with the increment; the zero case left flags clear.
	always_ff @(posedge clk) begin
		if (advance) begin
			neg_q_sf <= !stg_state[div128_pkg::NumStages].zero
				&& stg_state[div128_pkg::NumStages].neg_q;
			neg_r_sf <= !stg_state[div128_pkg::NumStages].zero
				&& stg_state[div128_pkg::NumStages].neg_r;
		end
	end

	assign quo_fix = quo_sf + {127'd0, neg_q_sf};
	assign rem_fix = rem_sf + {63'd0, neg_r_sf};

	// Hold the result word until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_sf;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			quotient_low    <= quo_fix[63:0];
			quotient_high   <= quo_fix[127:64];
			remainder_value <= rem_fix;
			zero_divisor    <= zero_sf;
		end
	end

	// A stalled output word must persist with its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quotient_low)
		&& $stable(remainder_value))
		else $error("output word changed while stalled");

	// The zero-divisor flag implies an all-ones quotient.
	a_zero_q: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_divisor |-> quotient_low == '1 && quotient_high == '1)
		else $error("zero divisor quotient not all ones");

	// Input is refused exactly while the output is stalled.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without a stall");

endmodule

// ----- bench/divide_128_by_64_checker.sv -----
// Checker for the 128-by-64 divider: predicts each quotient word and compares results.
module divide_128_by_64_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        req_type,
	input  logic [63:0] dividend_low,
	input  logic [63:0] dividend_high,
	input  logic [63:0] divisor_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] quotient_low,
	input  logic [63:0] quotient_high,
	input  logic [63:0] remainder_value,
	input  logic        zero_divisor,
	output int          fail_count,
	output int          pending_count,
	output int          checked_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [127:0] quot;
		logic [63:0]  rem;
		logic         zero;
	} quot_word_t;

	quot_word_t pending_quots[$];

	// Compute quotient and remainder of one division request.
	function automatic quot_word_t divide_word(logic sgn, logic [127:0] num, logic [63:0] den);
		quot_word_t w;
		logic neg_q;
		logic neg_r;
		logic [127:0] mag_n;
		logic [63:0] mag_d;
		neg_q = 1'b0;
		neg_r = 1'b0;
		mag_n = num;
		mag_d = den;
		if (den == '0) begin
			w.quot = '1;
			w.rem = num[63:0];
			w.zero = 1'b1;
			return w;
		end
		if (sgn && num[127]) begin
			neg_q = 1'b1;
			neg_r = 1'b1;
			mag_n = -num;
		end
		if (sgn && den[63]) begin
			neg_q = !neg_q;
			mag_d = -den;
		end
		w.quot = mag_n / {64'd0, mag_d};
		w.rem = 64'(mag_n % {64'd0, mag_d});
		if (neg_q)
			w.quot = -w.quot;
		if (neg_r)
			w.rem = -w.rem;
		w.zero = 1'b0;
		return w;
	endfunction

	// Predict on input handshake, compare on output handshake.
	always @(posedge clk or negedge arst_n) begin
		quot_word_t w;
		if (!arst_n) begin
			fail_count <= 0;
			checked_count <= 0;
			pending_count <= 0;
			pending_quots.delete();
		end else begin
			if (in_valid && in_ready)
				pending_quots.push_back(divide_word(req_type, {dividend_high, dividend_low},
					divisor_value));
			if (out_valid && out_ready) begin
				checked_count <= checked_count + 1;
				if (pending_quots.size() == 0) begin
					$display("%0t: unexpected word q=%h_%h r=%h z=%b", $time,
						quotient_high, quotient_low, remainder_value, zero_divisor);
					fail_count <= fail_count + 1;
				end else begin
					w = pending_quots.pop_front();
					if (w.quot != {quotient_high, quotient_low}) begin
						$display("%0t: quotient expected %h got %h", $time, w.quot,
							{quotient_high, quotient_low});
						fail_count <= fail_count + 1;
					end else if (w.rem != remainder_value) begin
						$display("%0t: remainder expected %h got %h", $time, w.rem,
							remainder_value);
						fail_count <= fail_count + 1;
					end else if (w.zero != zero_divisor) begin
						$display("%0t: zero_divisor expected %b got %b", $time, w.zero,
							zero_divisor);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= pending_quots.size();
		end
	end
endmodule

// ----- bench/tb_divide_128_by_64_top.sv -----
// Testbench top for the 128-by-64 divider: stimulus, idling phases and verdict.
module tb_divide_128_by_64_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = 1'b0;
	logic [63:0] dividend_low = '0;
	logic [63:0] dividend_high = '0;
	logic [63:0] divisor_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] quotient_low;
	logic [63:0] quotient_high;
	logic [63:0] remainder_value;
	logic        zero_divisor;
	int          fail_count;
	int          pending_count;
	int          checked_count;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_off_cycles = 0;
	int          sent_count = 0;

	always #2 clk = ~clk;

	divide_128_by_64_top DUT (.*);

	divide_128_by_64_checker u_checker (.*);

	// Drive out_ready: random stalls, or a long counted hold-off.
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			out_ready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Pick a divisor: mostly small or edge values so all paths get exercised.
	function automatic logic [63:0] pick_divisor();
		case ($urandom_range(7))
			0: return '0;
			1: return 64'd1;
			2: return '1;
			3: return 64'h8000_0000_0000_0000;
			4: return 64'($urandom_range(1000));
			5: return -64'($urandom_range(1000));
			default: return rand64();
		endcase
	endfunction

	// Offer one word, honoring the sender idle rate; hold until accepted.
	task automatic send_word(logic sgn, logic [63:0] lo, logic [63:0] hi, logic [63:0] den);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= sgn;
		dividend_low <= lo;
		dividend_high <= hi;
		divisor_value <= den;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic send_random(int n);
		logic [63:0] hi;
		repeat (n) begin
			case ($urandom_range(3))
				0: hi = '0;
				1: hi = '1;
				2: hi = 64'($urandom_range(1000));
				default: hi = rand64();
			endcase
			send_word(1'($urandom_range(1)), rand64(), hi, pick_divisor());
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	initial begin
		#400000;
		$display("tb_divide_128_by_64_top failed");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: field extremes, both modes, zero divisor, wrap case.
		for (int s = 0; s < 2; s++) begin
			send_word(1'(s), '0, '0, 64'd1);
			send_word(1'(s), '1, '1, 64'd1);
			send_word(1'(s), '1, '1, '0);
			send_word(1'(s), 64'h1234, 64'h8000_0000_0000_0000, '0);
			send_word(1'(s), '0, 64'h8000_0000_0000_0000, '1);
			send_word(1'(s), '1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
			send_word(1'(s), 64'd7, '0, -64'd2);
			send_word(1'(s), -64'd7, '1, 64'd2);
			send_word(1'(s), -64'd7, '1, -64'd2);
			send_word(1'(s), '1, '1, '1);
			send_word(1'(s), 64'hFFFF_0000_FFFF_0000, 64'h5555_AAAA_5555_AAAA,
				64'h8000_0000_0000_0001);
		end
		drain();
		// Random phases: free flow, slow sender, slow receiver, both slow.
		send_random(400);
		send_idle_pct = 78;
		send_random(300);
		send_idle_pct = 0;
		recv_stall_pct = 78;
		send_random(300);
		send_idle_pct = 8;
		recv_stall_pct = 8;
		send_random(300);
		// Long receiver hold-off while the sender keeps offering.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles <= 200;
		send_random(100);
		// Sender pauses until every result is back, then resumes.
		drain();
		send_random(300);
		drain();
		repeat (40) @(posedge clk);
		$display("Sent %0d division words, checked %0d results across four idling phases",
			sent_count, checked_count);
		$display("and a long output hold-off, covering both modes and divide-by-zero.");
		if (fail_count == 0 && pending_count == 0)
			$display("tb_divide_128_by_64_top passed");
		else
			$display("tb_divide_128_by_64_top failed");
		$finish;
	end
endmodule
